[hdl/stxdf_pkg.sv]
// Package for the STX/ETX response deframer.
// Holds word types, framing codes and status codes; no dependencies.
`default_nettype none

package stxdf_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned POS_W    = 2;

  localparam int unsigned DEF_MAX_PAYLOAD = 255;

  localparam logic [BYTE_W-1:0] ETX_CODE  = 8'h03;
  localparam logic [BYTE_W-1:0] SUM_FLOOR = 8'h20;

  // header position
  localparam logic [POS_W-1:0] POS_START   = 2'd0;
  localparam logic [POS_W-1:0] POS_LENGTH  = 2'd1;
  localparam logic [POS_W-1:0] POS_COMMAND = 2'd2;
  localparam logic [POS_W-1:0] POS_BODY    = 2'd3;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_SUM = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_CMD = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic                item_kind;
    logic [BYTE_W-1:0]   data_byte;
    logic [STATUS_W-1:0] frame_status;
    logic [COUNT_W-1:0]  data_count;
  } out_word_t;

endpackage

`default_nettype wire

[hdl/stxdf_if.sv]
// Valid/ready channel interfaces for the STX/ETX response deframer.
// Depends on stxdf_pkg for the word types.
`default_nettype none

interface stxdf_in_if;
  logic                valid;
  logic                ready;
  stxdf_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface stxdf_out_if;
  logic                 valid;
  logic                 ready;
  stxdf_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/stx_etx_response_deframer_unit.sv]
// Top level of the STX/ETX response deframer.
// Depends on stxdf_pkg and the channel interfaces in stxdf_if.
//
// Usage:
//   in_ch  : one received byte per word (rx_byte), valid/ready.
//   out_ch : result words; item_kind 0 releases a payload byte, item_kind 1
//            ends a frame with frame_status and the saturating data_count.
//   cfg_   : cfg_wr_en/cfg_wr_data write expected_command; write while idle.
// A frame is start, length, command, body, checksum, ETX. Body bytes are
// held one word and released when the next non-ETX body byte arrives.
// A result appears on out_ch in the cycle after the input word that
// causes it is accepted. Throughput: one input word per cycle when not stalled.
// The result register lets a new word in while the previous result is
// being taken; in_ch.ready drops only while a result waits and out_ch.ready
// is low, so a stalled receiver holds the input off without losing words.
// Reset (rst_n low, synchronous) clears frame state, the result valid flag
// and expected_command; the next byte is taken as a start byte.
`default_nettype none

module stx_etx_response_deframer_unit #(
  parameter int unsigned MAX_PAYLOAD = stxdf_pkg::DEF_MAX_PAYLOAD
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  stxdf_in_if.sink                            in_ch,
  stxdf_out_if.source                         out_ch,
  input  wire logic                           cfg_wr_en,
  input  wire logic [stxdf_pkg::BYTE_W-1:0]   cfg_wr_data
);

  localparam logic [stxdf_pkg::COUNT_W-1:0] MAX_CNT = stxdf_pkg::COUNT_W'(MAX_PAYLOAD);

  logic [stxdf_pkg::BYTE_W-1:0]  expected_r;
  logic [stxdf_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic [stxdf_pkg::BYTE_W-1:0]  cmd_r, cmd_nxt;
  logic [stxdf_pkg::BYTE_W-1:0]  sum_r, sum_nxt;
  logic [stxdf_pkg::BYTE_W-1:0]  held_r, held_nxt;
  logic                          held_valid_r, held_valid_nxt;
  logic [stxdf_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic                          out_valid_r;
  stxdf_pkg::out_word_t          out_word_r, res;
  logic                          res_valid;

  logic                          accept;
  logic [stxdf_pkg::BYTE_W-1:0]  b;
  logic                          is_etx;
  logic [stxdf_pkg::BYTE_W-1:0]  sum_adj;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign accept       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_word_r;

  assign b       = in_ch.data.rx_byte;
  assign is_etx  = (b == stxdf_pkg::ETX_CODE);
  assign sum_adj = (sum_r < stxdf_pkg::SUM_FLOOR) ? sum_r + stxdf_pkg::SUM_FLOOR : sum_r;

  always_comb begin
    pos_nxt        = pos_r;
    cmd_nxt        = cmd_r;
    sum_nxt        = sum_r;
    held_nxt       = held_r;
    held_valid_nxt = held_valid_r;
    count_nxt      = count_r;
    res_valid      = 1'b0;
    res            = '0;
    case (pos_r)
      stxdf_pkg::POS_START: begin
        pos_nxt = stxdf_pkg::POS_LENGTH;
      end
      stxdf_pkg::POS_LENGTH: begin
        sum_nxt = b;
        pos_nxt = stxdf_pkg::POS_COMMAND;
      end
      stxdf_pkg::POS_COMMAND: begin
        cmd_nxt = b;
        sum_nxt = sum_r + b;
        pos_nxt = stxdf_pkg::POS_BODY;
      end
      default: begin
        if (is_etx) begin
          res_valid      = 1'b1;
          res.item_kind  = stxdf_pkg::KIND_END;
          res.data_count = count_r;
          if (!held_valid_r || sum_adj != held_r) begin
            res.frame_status = stxdf_pkg::ST_BAD_SUM;
          end else if (cmd_r != expected_r) begin
            res.frame_status = stxdf_pkg::ST_BAD_CMD;
          end else begin
            res.frame_status = stxdf_pkg::ST_OK;
          end
          pos_nxt        = stxdf_pkg::POS_START;
          cmd_nxt        = '0;
          sum_nxt        = '0;
          held_nxt       = '0;
          held_valid_nxt = 1'b0;
          count_nxt      = '0;
        end else if (held_valid_r) begin
          res_valid     = 1'b1;
          res.item_kind = stxdf_pkg::KIND_DATA;
          res.data_byte = held_r;
          sum_nxt       = sum_r + held_r;
          if (count_r < MAX_CNT) begin
            count_nxt = count_r + 1'b1;
          end
          held_nxt = b;
        end else begin
          held_nxt       = b;
          held_valid_nxt = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_r   <= '0;
      pos_r        <= stxdf_pkg::POS_START;
      cmd_r        <= '0;
      sum_r        <= '0;
      held_r       <= '0;
      held_valid_r <= 1'b0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        expected_r <= cfg_wr_data;
      end
      if (accept) begin
        pos_r        <= pos_nxt;
        cmd_r        <= cmd_nxt;
        sum_r        <= sum_nxt;
        held_r       <= held_nxt;
        held_valid_r <= held_valid_nxt;
        count_r      <= count_nxt;
      end
      if (accept && res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      out_word_r <= res;
    end
  end

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && pos_r == stxdf_pkg::POS_BODY && is_etx)
      |=> (pos_r == stxdf_pkg::POS_START && !held_valid_r && count_r == '0))
    else $error("frame state not cleared after ETX");

  a_release: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && pos_r == stxdf_pkg::POS_BODY && !is_etx && held_valid_r)
      |=> (out_valid_r && out_word_r.item_kind == stxdf_pkg::KIND_DATA))
    else $error("held byte not released");

  a_held_in_body: assert property (@(posedge clk) disable iff (!rst_n)
    held_valid_r |-> pos_r == stxdf_pkg::POS_BODY)
    else $error("held byte outside frame body");

  a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_CNT)
    else $error("payload count above limit");

endmodule

`default_nettype wire
